>>> hdl/psl_pkg.sv
package psl_pkg;

    localparam int KEYWORD_MAX_CHARS_DEF = 12;
    localparam int LENGTH_BITS_DEF       = 16;

    localparam int BYTE_W   = 8;
    localparam int CODE_W   = 9;
    localparam int POS_W    = 32;
    localparam int KW_N     = 35;
    localparam int KW_CHARS = 12;
    localparam int KW_LEN_W = 5;

    typedef logic signed [CODE_W-1:0] t_code;

    localparam t_code TOK_EOF   = t_code'(-1);
    localparam t_code TOK_INT   = t_code'(-2);
    localparam t_code TOK_REAL  = t_code'(-3);
    localparam t_code TOK_STR   = t_code'(-4);
    localparam t_code TOK_BOOL  = t_code'(-5);
    localparam t_code TOK_IDENT = t_code'(-6);

    localparam logic [BYTE_W-1:0] CH_TAB        = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF         = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DQUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_HASH       = 8'h23;
    localparam logic [BYTE_W-1:0] CH_SQUOTE     = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DOT        = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;

    // Keyword spellings are right-aligned: the last letter sits in the low byte.
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_N] = '{
        "INICIO", "FIN", "LEER", "IMPRIMIR", "SI", "ENTONCES", "FINSI", "MIENTRAS",
        "HACER", "FINMIENTRAS", "REPETIR", "HASTAQUE", "DESDE", "PASO", "HASTA",
        "FINDESDE", "FUNCION", "RETORNAR", "FINFUNCION", "CLASE", "PUBLICO",
        "PRIVADO", "CONSTRUCTOR", "FINCLASE", "EXTIENDEA", "ENCASOQUE",
        "SEAIGUALQUE", "FINCASO", "FINENCASOQUE", "NUMERO", "ENTERO", "TEXTO",
        "BOOLEANO", "VERDADERO", "FALSO"
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_N] = '{
        5'd6, 5'd3, 5'd4, 5'd8, 5'd2, 5'd8, 5'd5, 5'd8,
        5'd5, 5'd11, 5'd7, 5'd8, 5'd5, 5'd4, 5'd5,
        5'd8, 5'd7, 5'd8, 5'd10, 5'd5, 5'd7,
        5'd7, 5'd11, 5'd8, 5'd9, 5'd9,
        5'd11, 5'd7, 5'd12, 5'd6, 5'd6, 5'd5,
        5'd8, 5'd9, 5'd5
    };

    localparam t_code KW_CODE [KW_N] = '{
        t_code'(-7), t_code'(-8), t_code'(-9), t_code'(-10), t_code'(-11),
        t_code'(-12), t_code'(-13), t_code'(-14), t_code'(-15), t_code'(-16),
        t_code'(-17), t_code'(-18), t_code'(-19), t_code'(-21), t_code'(-20),
        t_code'(-22), t_code'(-34), t_code'(-35), t_code'(-36), t_code'(-37),
        t_code'(-38), t_code'(-39), t_code'(-40), t_code'(-42), t_code'(-41),
        t_code'(-23), t_code'(-24), t_code'(-26), t_code'(-27), t_code'(-29),
        t_code'(-28), t_code'(-30), t_code'(-31), TOK_BOOL, TOK_BOOL
    };

endpackage

>>> hdl/pseudocode_lexer_unit.sv
// Channel   Direction  tdata                                   tuser / tlast
// s_axis    in         byte_req                                tuser: kind
// m_axis    out        token_code, token_start, token_length   tlast: last
//
// One source byte is taken per cycle while ready. The byte is classified and the
// lexer state updated in the cycle of its transfer; its zero, one or two tokens
// are written into a four-entry result queue that drives m_axis. Bytes that give
// two tokens make the output side the limit at one token per cycle. s_axis_tready
// drops while the queue holds three or more tokens. Reset is synchronous and
// empties the queue; the lexer starts idle at stream position zero.
module pseudocode_lexer_unit
    import psl_pkg::*;
#(
    parameter int KEYWORD_MAX_CHARS = KEYWORD_MAX_CHARS_DEF,
    parameter int LENGTH_BITS       = LENGTH_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] byte_req
    input  logic                 s_axis_tuser,   // [0] kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // token_code, token_start, token_length, then zero fill
    output logic [((CODE_W+POS_W+LENGTH_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                 m_axis_tlast    // last
);

    localparam int OUT_W   = ((CODE_W + POS_W + LENGTH_BITS + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(KEYWORD_MAX_CHARS + 1);
    localparam int IDX_W   = $clog2(KEYWORD_MAX_CHARS);
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = 2;
    localparam int QC_W    = 3;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    typedef enum logic [2:0] {
        M_IDLE,
        M_WORD,
        M_NUMBER,
        M_TEXT,
        M_COMMENT
    } t_mode;

    typedef struct packed {
        t_code                  code;
        logic [POS_W-1:0]       start;
        logic [LENGTH_BITS-1:0] len;
        logic                   last;
    } t_tok;

    t_mode                   r_mode, n_mode;
    logic [CNT_W-1:0]        r_word_count, n_word_count;
    logic                    r_dot_seen, n_dot_seen;
    logic [BYTE_W-1:0]       r_open_quote, n_open_quote;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [POS_W-1:0]        r_lex_start, n_lex_start;
    logic [LENGTH_BITS-1:0]  r_lex_len, n_lex_len;
    logic [BYTE_W-1:0]       r_word_chars [KEYWORD_MAX_CHARS];

    t_tok                    r_queue [Q_DEPTH];
    logic [QP_W-1:0]         r_rd_ptr, n_rd_ptr;
    logic [QP_W-1:0]         r_wr_ptr, n_wr_ptr;
    logic [QC_W-1:0]         r_q_count, n_q_count;

    logic                    in_xfer, out_xfer;
    logic [BYTE_W-1:0]       in_byte;
    logic                    is_alpha, is_digit, is_space;
    logic                    wc_we;
    logic [IDX_W-1:0]        wc_idx;
    t_code                   word_code;
    t_code                   num_code;
    logic [LENGTH_BITS-1:0]  len_inc;
    t_tok                    tok0, tok1;
    logic                    tok0_v, tok1_v;
    logic [1:0]              res_cnt;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign in_byte  = s_axis_tdata;

    assign s_axis_tready = (r_q_count < QC_W'(Q_DEPTH - 1));
    assign m_axis_tvalid = (r_q_count != '0);
    assign m_axis_tdata  = OUT_W'({r_queue[r_rd_ptr].len, r_queue[r_rd_ptr].start,
                                   r_queue[r_rd_ptr].code});
    assign m_axis_tlast  = r_queue[r_rd_ptr].last;

    assign is_alpha = ((in_byte >= "A") && (in_byte <= "Z"))
                   || ((in_byte >= "a") && (in_byte <= "z"));
    assign is_digit = (in_byte >= "0") && (in_byte <= "9");
    assign is_space = (in_byte == CH_SPACE) || (in_byte == CH_TAB)
                   || (in_byte == CH_CR) || (in_byte == CH_LF);

    assign num_code = r_dot_seen ? TOK_REAL : TOK_INT;
    assign len_inc  = (r_lex_len == LEN_MAX) ? r_lex_len : r_lex_len + 1'b1;

    // Parallel compare of the stored word against every keyword. A word longer
    // than what was stored can never be a keyword.
    always_comb begin
        logic                hit;
        logic                found;
        logic [KW_LEN_W-1:0] wc_ext;
        int                  pos;
        word_code = TOK_IDENT;
        found     = 1'b0;
        hit       = 1'b0;
        pos       = 0;
        wc_ext    = KW_LEN_W'(r_word_count);
        for (int i = 0; i < KW_N; i++) begin
            hit = (KW_LEN[i] == wc_ext);
            for (int k = 0; k < KW_CHARS; k++) begin
                if (k < int'(KW_LEN[i])) begin
                    pos = int'(KW_LEN[i]) - 1 - k;
                    hit = hit && (r_word_chars[k] == KW_TEXT[i][8*pos +: 8]);
                end
            end
            if (hit && !found) begin
                word_code = KW_CODE[i];
                found     = 1'b1;
            end
        end
        if (r_lex_len != LENGTH_BITS'(r_word_count)) begin
            word_code = TOK_IDENT;
        end
    end

    always_comb begin
        logic redo;
        n_mode       = r_mode;
        n_word_count = r_word_count;
        n_dot_seen   = r_dot_seen;
        n_open_quote = r_open_quote;
        n_pos        = r_pos;
        n_lex_start  = r_lex_start;
        n_lex_len    = r_lex_len;
        wc_we        = 1'b0;
        wc_idx       = r_word_count[IDX_W-1:0];
        tok0         = '{code: TOK_EOF, start: r_pos, len: '0, last: 1'b0};
        tok1         = '{code: TOK_EOF, start: r_pos, len: '0, last: 1'b1};
        tok0_v       = 1'b0;
        tok1_v       = 1'b0;
        redo         = 1'b0;

        if (in_xfer) begin
            if (s_axis_tuser) begin
                // End of stream: flush an open token, then EOF.
                unique case (r_mode)
                    M_WORD: begin
                        tok0   = '{code: word_code, start: r_lex_start, len: r_lex_len,
                                   last: 1'b0};
                        tok0_v = 1'b1;
                    end
                    M_NUMBER: begin
                        tok0   = '{code: num_code, start: r_lex_start, len: r_lex_len,
                                   last: 1'b0};
                        tok0_v = 1'b1;
                    end
                    M_TEXT: begin
                        tok0   = '{code: TOK_STR, start: r_lex_start, len: r_lex_len,
                                   last: 1'b0};
                        tok0_v = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (tok0_v) begin
                    tok1_v = 1'b1;
                end else begin
                    tok0   = '{code: TOK_EOF, start: r_pos, len: '0, last: 1'b1};
                    tok0_v = 1'b1;
                end
                n_mode = M_IDLE;
            end else begin
                unique case (r_mode)
                    M_TEXT: begin
                        n_lex_len = len_inc;
                        if (in_byte == r_open_quote) begin
                            tok0   = '{code: TOK_STR, start: r_lex_start, len: len_inc,
                                       last: 1'b0};
                            tok0_v = 1'b1;
                            n_mode = M_IDLE;
                        end
                    end
                    M_COMMENT: begin
                        if ((in_byte == CH_LF) || (in_byte == CH_CR)) begin
                            n_mode = M_IDLE;
                        end
                    end
                    M_WORD: begin
                        if (is_alpha || is_digit || (in_byte == CH_UNDERSCORE)) begin
                            if (r_word_count < CNT_W'(KEYWORD_MAX_CHARS)) begin
                                wc_we        = 1'b1;
                                n_word_count = r_word_count + 1'b1;
                            end
                            n_lex_len = len_inc;
                        end else begin
                            tok0   = '{code: word_code, start: r_lex_start, len: r_lex_len,
                                       last: 1'b0};
                            tok0_v = 1'b1;
                            redo   = 1'b1;
                        end
                    end
                    M_NUMBER: begin
                        if (is_digit || (in_byte == CH_DOT)) begin
                            if (in_byte == CH_DOT) begin
                                n_dot_seen = 1'b1;
                            end
                            n_lex_len = len_inc;
                        end else begin
                            tok0   = '{code: num_code, start: r_lex_start, len: r_lex_len,
                                       last: 1'b0};
                            tok0_v = 1'b1;
                            redo   = 1'b1;
                        end
                    end
                    M_IDLE: begin
                        redo = 1'b1;
                    end
                    default: begin
                        redo = 1'b1;
                    end
                endcase

                // The byte that ends a word or number is treated as a fresh byte.
                if (redo) begin
                    n_mode = M_IDLE;
                    if (is_space) begin
                        n_mode = M_IDLE;
                    end else if (is_digit || is_alpha || (in_byte == CH_UNDERSCORE)
                                 || (in_byte == CH_DQUOTE) || (in_byte == CH_SQUOTE)) begin
                        n_lex_start  = r_pos;
                        n_lex_len    = LENGTH_BITS'(1);
                        n_word_count = '0;
                        n_dot_seen   = 1'b0;
                        if (is_digit) begin
                            n_mode = M_NUMBER;
                        end else if (is_alpha || (in_byte == CH_UNDERSCORE)) begin
                            n_mode       = M_WORD;
                            wc_we        = 1'b1;
                            wc_idx       = '0;
                            n_word_count = CNT_W'(1);
                        end else begin
                            n_mode       = M_TEXT;
                            n_open_quote = in_byte;
                        end
                    end else if (in_byte == CH_HASH) begin
                        n_mode = M_COMMENT;
                    end else begin
                        if (tok0_v) begin
                            tok1   = '{code: t_code'({1'b0, in_byte}), start: r_pos,
                                       len: LENGTH_BITS'(1), last: 1'b1};
                            tok1_v = 1'b1;
                        end else begin
                            tok0   = '{code: t_code'({1'b0, in_byte}), start: r_pos,
                                       len: LENGTH_BITS'(1), last: 1'b0};
                            tok0_v = 1'b1;
                        end
                    end
                end
                n_pos = r_pos + 1'b1;
                if (!tok1_v) begin
                    tok0.last = 1'b1;
                end
            end
        end
    end

    assign res_cnt = {1'b0, tok0_v} + {1'b0, tok1_v};

    always_comb begin
        n_wr_ptr  = r_wr_ptr + QP_W'(res_cnt);
        n_rd_ptr  = out_xfer ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_q_count = r_q_count + QC_W'(res_cnt) - QC_W'(out_xfer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_IDLE;
            r_word_count <= '0;
            r_dot_seen   <= 1'b0;
            r_open_quote <= '0;
            r_pos        <= '0;
            r_lex_start  <= '0;
            r_lex_len    <= '0;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_q_count    <= '0;
        end else begin
            r_mode       <= n_mode;
            r_word_count <= n_word_count;
            r_dot_seen   <= n_dot_seen;
            r_open_quote <= n_open_quote;
            r_pos        <= n_pos;
            r_lex_start  <= n_lex_start;
            r_lex_len    <= n_lex_len;
            r_rd_ptr     <= n_rd_ptr;
            r_wr_ptr     <= n_wr_ptr;
            r_q_count    <= n_q_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wc_we) begin
            r_word_chars[wc_idx] <= in_byte;
        end
        if (tok0_v) begin
            r_queue[r_wr_ptr] <= tok0;
        end
        if (tok1_v) begin
            r_queue[r_wr_ptr + 1'b1] <= tok1;
        end
    end

endmodule

>>> tb/lexer_token_check.sv
`timescale 1ns / 100ps

// Watches both streams of the lexer, replays every accepted source transfer through
// its own tokenizer and compares each token transfer with the oldest one predicted.
module lexer_token_check
    import psl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_src_valid,
    input  logic                  i_src_ready,
    input  logic [BYTE_W-1:0]     i_src_data,     // [7:0] byte_req
    input  logic                  i_src_user,     // [0] kind
    input  logic                  i_tok_valid,
    input  logic                  i_tok_ready,
    // [8:0] token_code, [40:9] token_start, [56:41] token_length, then zero fill
    input  logic [((CODE_W+POS_W+LENGTH_BITS_DEF+7)/8)*8-1:0] i_tok_data,
    input  logic                  i_tok_last,     // last
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_tokens_seen,
    output int                    o_longest
);

    localparam int LEN_W    = LENGTH_BITS_DEF;
    localparam int WORD_MAX = KEYWORD_MAX_CHARS_DEF;

    typedef enum logic [2:0] {LX_IDLE, LX_WORD, LX_NUMBER, LX_TEXT, LX_COMMENT} t_lex_mode;

    typedef enum int {
        TK_INICIO = -7, TK_FIN = -8, TK_LEER = -9, TK_IMPRIMIR = -10, TK_SI = -11,
        TK_ENTONCES = -12, TK_FINSI = -13, TK_MIENTRAS = -14, TK_HACER = -15,
        TK_FINMIENTRAS = -16, TK_REPETIR = -17, TK_HASTAQUE = -18, TK_DESDE = -19,
        TK_HASTA = -20, TK_PASO = -21, TK_FINDESDE = -22, TK_ENCASOQUE = -23,
        TK_SEAIGUALQUE = -24, TK_FINCASO = -26, TK_FINENCASOQUE = -27, TK_ENTERO = -28,
        TK_NUMERO = -29, TK_TEXTO = -30, TK_BOOLEANO = -31, TK_FUNCION = -34,
        TK_RETORNAR = -35, TK_FINFUNCION = -36, TK_CLASE = -37, TK_PUBLICO = -38,
        TK_PRIVADO = -39, TK_CONSTRUCTOR = -40, TK_EXTIENDEA = -41, TK_FINCLASE = -42
    } t_keyword_code;

    typedef struct packed {
        t_code            code;
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_token;

    t_lex_mode         mode;
    logic [BYTE_W-1:0] word_chars [WORD_MAX];
    int                word_count;
    logic              dot_seen;
    logic [BYTE_W-1:0] open_quote;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  lexeme_start;
    logic [LEN_W-1:0]  lexeme_len;
    t_token            upcoming_tokens [$];
    t_token            item_tokens [2];
    int                item_count;

    function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Words are packed right-aligned so they compare directly with string literals.
    function automatic int word_code();
        logic [8*WORD_MAX-1:0] w;
        w = '0;
        if (int'(lexeme_len) != word_count) return TOK_IDENT;
        for (int i = 0; i < word_count; i++) w = {w[8*WORD_MAX-9:0], word_chars[i]};
        case (w)
            "INICIO":       return TK_INICIO;
            "FIN":          return TK_FIN;
            "LEER":         return TK_LEER;
            "IMPRIMIR":     return TK_IMPRIMIR;
            "SI":           return TK_SI;
            "ENTONCES":     return TK_ENTONCES;
            "FINSI":        return TK_FINSI;
            "MIENTRAS":     return TK_MIENTRAS;
            "HACER":        return TK_HACER;
            "FINMIENTRAS":  return TK_FINMIENTRAS;
            "REPETIR":      return TK_REPETIR;
            "HASTAQUE":     return TK_HASTAQUE;
            "DESDE":        return TK_DESDE;
            "HASTA":        return TK_HASTA;
            "PASO":         return TK_PASO;
            "FINDESDE":     return TK_FINDESDE;
            "ENCASOQUE":    return TK_ENCASOQUE;
            "SEAIGUALQUE":  return TK_SEAIGUALQUE;
            "FINCASO":      return TK_FINCASO;
            "FINENCASOQUE": return TK_FINENCASOQUE;
            "ENTERO":       return TK_ENTERO;
            "NUMERO":       return TK_NUMERO;
            "TEXTO":        return TK_TEXTO;
            "BOOLEANO":     return TK_BOOLEANO;
            "FUNCION":      return TK_FUNCION;
            "RETORNAR":     return TK_RETORNAR;
            "FINFUNCION":   return TK_FINFUNCION;
            "CLASE":        return TK_CLASE;
            "PUBLICO":      return TK_PUBLICO;
            "PRIVADO":      return TK_PRIVADO;
            "CONSTRUCTOR":  return TK_CONSTRUCTOR;
            "EXTIENDEA":    return TK_EXTIENDEA;
            "FINCLASE":     return TK_FINCLASE;
            "VERDADERO", "FALSO": return TOK_BOOL;
            default:        return TOK_IDENT;
        endcase
    endfunction

    function automatic void add_token(input int code, input logic [POS_W-1:0] start,
                                      input logic [LEN_W-1:0] len);
        item_tokens[item_count].code  = t_code'(code);
        item_tokens[item_count].start = start;
        item_tokens[item_count].len   = len;
        item_tokens[item_count].last  = 1'b0;
        item_count++;
    endfunction

    function automatic void open_lexeme(input t_lex_mode m);
        mode         = m;
        lexeme_start = position;
        lexeme_len   = 1;
        word_count   = 0;
        dot_seen     = 1'b0;
    endfunction

    function automatic void grow_lexeme();
        if (lexeme_len != '1) lexeme_len++;
    endfunction

    function automatic void lex_item(input logic end_mark, input logic [BYTE_W-1:0] b);
        t_token tok;
        item_count = 0;
        if (end_mark) begin
            if (mode == LX_WORD) add_token(word_code(), lexeme_start, lexeme_len);
            else if (mode == LX_NUMBER)
                add_token(dot_seen ? TOK_REAL : TOK_INT, lexeme_start, lexeme_len);
            else if (mode == LX_TEXT) add_token(TOK_STR, lexeme_start, lexeme_len);
            add_token(TOK_EOF, position, '0);
            mode = LX_IDLE;
        end else begin
            if (mode == LX_TEXT) begin
                grow_lexeme();
                if (b == open_quote) begin
                    add_token(TOK_STR, lexeme_start, lexeme_len);
                    mode = LX_IDLE;
                end
            end else if (mode == LX_COMMENT) begin
                if (b == CH_LF || b == CH_CR) mode = LX_IDLE;
            end else begin
                if (mode == LX_WORD) begin
                    if (is_alpha(b) || is_digit(b) || b == CH_UNDERSCORE) begin
                        if (word_count < WORD_MAX) begin
                            word_chars[word_count] = b;
                            word_count++;
                        end
                        grow_lexeme();
                    end else begin
                        add_token(word_code(), lexeme_start, lexeme_len);
                        mode = LX_IDLE;
                    end
                end else if (mode == LX_NUMBER) begin
                    if (is_digit(b) || b == CH_DOT) begin
                        if (b == CH_DOT) dot_seen = 1'b1;
                        grow_lexeme();
                    end else begin
                        add_token(dot_seen ? TOK_REAL : TOK_INT, lexeme_start, lexeme_len);
                        mode = LX_IDLE;
                    end
                end
                // The byte that closed a word or number starts over from idle.
                if (mode == LX_IDLE) begin
                    if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
                    end else if (is_alpha(b) || b == CH_UNDERSCORE) begin
                        open_lexeme(LX_WORD);
                        word_chars[0] = b;
                        word_count    = 1;
                    end else if (is_digit(b)) begin
                        open_lexeme(LX_NUMBER);
                    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                        open_lexeme(LX_TEXT);
                        open_quote = b;
                    end else if (b == CH_HASH) begin
                        mode = LX_COMMENT;
                    end else begin
                        add_token(int'(b), position, LEN_W'(1));
                    end
                end
            end
            position++;
        end
        for (int i = 0; i < item_count; i++) begin
            tok      = item_tokens[i];
            tok.last = (i == item_count - 1);
            upcoming_tokens.push_back(tok);
        end
    endfunction

    task automatic report_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_token           want;
        t_code            got_code;
        logic [POS_W-1:0] got_start;
        logic [LEN_W-1:0] got_len;
        if (!i_rst_n) begin
            mode         = LX_IDLE;
            word_count   = 0;
            dot_seen     = 1'b0;
            open_quote   = '0;
            position     = '0;
            lexeme_start = '0;
            lexeme_len   = '0;
            upcoming_tokens.delete();
        end else begin
            // Tokens leave no earlier than the cycle after their byte, so compare first.
            if (i_tok_valid && i_tok_ready) begin
                got_code  = t_code'(i_tok_data[CODE_W-1:0]);
                got_start = i_tok_data[CODE_W +: POS_W];
                got_len   = i_tok_data[CODE_W+POS_W +: LEN_W];
                o_tokens_seen++;
                if (int'(got_len) > o_longest) o_longest = int'(got_len);
                if (upcoming_tokens.size() == 0) begin
                    $display({"%0t ns: token transfer with none expected, ",
                              "actual code %0d start %0d length %0d"},
                             $time, got_code, got_start, got_len);
                    o_fail_count++;
                end else begin
                    want = upcoming_tokens.pop_front();
                    report_field("token_code", longint'(signed'(want.code)),
                                 longint'(got_code));
                    report_field("token_start", longint'(want.start), longint'(got_start));
                    report_field("token_length", longint'(want.len), longint'(got_len));
                    report_field("last", longint'(want.last), longint'(i_tok_last));
                end
            end
            if (i_src_valid && i_src_ready) lex_item(i_src_user, i_src_data);
        end
        o_pending = upcoming_tokens.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import psl_pkg::*;

    localparam int     TOK_W           = ((CODE_W + POS_W + LENGTH_BITS_DEF + 7) / 8) * 8;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     DRAIN_CYCLES    = 20;
    localparam longint TIMEOUT_NS      = 2_000_000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata  = '0;     // [7:0] byte_req
    logic               s_axis_tuser  = 1'b0;   // [0] kind
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TOK_W-1:0]   m_axis_tdata;           // [8:0] code, [40:9] start, [56:41] length
    logic               m_axis_tlast;           // last

    int    fail_count;
    int    pending_tokens;
    int    tokens_seen;
    int    longest_token;
    bit    src_gaps       = 1'b1;
    bit    sink_gaps      = 1'b1;
    bit    sink_hold_req  = 1'b0;
    int    sink_hold_left = 0;
    int    bytes_sent     = 0;
    int    eofs_sent      = 0;
    int    longest_kw     = 0;
    string symbols        = "+-*/=<>()[]{},;:!&|%^~?@$";
    string keywords [KW_N] = '{
        "INICIO", "FIN", "LEER", "IMPRIMIR", "SI", "ENTONCES", "FINSI", "MIENTRAS",
        "HACER", "FINMIENTRAS", "REPETIR", "HASTAQUE", "DESDE", "PASO", "HASTA",
        "FINDESDE", "FUNCION", "RETORNAR", "FINFUNCION", "CLASE", "PUBLICO",
        "PRIVADO", "CONSTRUCTOR", "FINCLASE", "EXTIENDEA", "ENCASOQUE",
        "SEAIGUALQUE", "FINCASO", "FINENCASOQUE", "NUMERO", "ENTERO", "TEXTO",
        "BOOLEANO", "VERDADERO", "FALSO"
    };

    pseudocode_lexer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    lexer_token_check token_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_src_valid   (s_axis_tvalid),
        .i_src_ready   (s_axis_tready),
        .i_src_data    (s_axis_tdata),
        .i_src_user    (s_axis_tuser),
        .i_tok_valid   (m_axis_tvalid),
        .i_tok_ready   (m_axis_tready),
        .i_tok_data    (m_axis_tdata),
        .i_tok_last    (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending_tokens),
        .o_tokens_seen (tokens_seen),
        .o_longest     (longest_token)
    );

    always #10 i_clk = ~i_clk;

    // Token sink: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_hold_req) begin
            sink_hold_req  = 1'b0;
            sink_hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(sink_gaps && $urandom_range(99) < 9);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("testbench failed");
        $finish;
    end

    task automatic send_item(input logic end_mark, input logic [BYTE_W-1:0] b);
        while (src_gaps && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= end_mark;
        do @(posedge i_clk); while (!s_axis_tready);
        if (end_mark) eofs_sent++;
        else bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
    endtask

    task automatic send_eof();
        send_item(1'b1, 8'($urandom_range(255)));
    endtask

    task automatic drain_tokens();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending_tokens == 0);
    endtask

    function automatic logic [BYTE_W-1:0] word_head_char();
        int r;
        r = $urandom_range(52);
        if (r < 26) return 8'(r) + "A";
        if (r < 52) return 8'(r - 26) + "a";
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [BYTE_W-1:0] word_tail_char();
        int r;
        r = $urandom_range(62);
        if (r < 26) return 8'(r) + "A";
        if (r < 52) return 8'(r - 26) + "a";
        if (r < 62) return 8'(r - 52) + "0";
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [BYTE_W-1:0] blank_char();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    task automatic gen_keyword();
        int                k;
        logic [BYTE_W-1:0] c;
        k = $urandom_range(KW_N - 1);
        if ($urandom_range(9) == 0) k = longest_kw;
        for (int i = 0; i < keywords[k].len(); i++) begin
            c = keywords[k][i];
            // A lower-case letter turns the keyword into a plain identifier.
            if ($urandom_range(19) == 0) c = c | 8'h20;
            send_item(1'b0, c);
        end
        if ($urandom_range(5) == 0) repeat ($urandom_range(1, 3)) send_item(1'b0, word_tail_char());
    endtask

    task automatic gen_ident();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(11, 16) : $urandom_range(1, 6);
        send_item(1'b0, word_head_char());
        repeat (n - 1) send_item(1'b0, word_tail_char());
    endtask

    task automatic gen_number();
        send_item(1'b0, 8'($urandom_range(9)) + "0");
        repeat ($urandom_range(0, 6))
            send_item(1'b0, ($urandom_range(4) == 0) ? CH_DOT : 8'($urandom_range(9)) + "0");
    endtask

    task automatic gen_text();
        logic [BYTE_W-1:0] q;
        logic [BYTE_W-1:0] c;
        q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        send_item(1'b0, q);
        repeat ($urandom_range(0, 8)) begin
            do c = 8'($urandom_range(255)); while (c == q);
            send_item(1'b0, c);
        end
        // Now and then the text is left open and runs into what follows.
        if ($urandom_range(9) != 0) send_item(1'b0, q);
    endtask

    task automatic gen_comment();
        logic [BYTE_W-1:0] c;
        send_item(1'b0, CH_HASH);
        repeat ($urandom_range(0, 8)) begin
            do c = 8'($urandom_range(255)); while (c == CH_CR || c == CH_LF);
            send_item(1'b0, c);
        end
        if ($urandom_range(7) == 0) send_eof();
        else send_item(1'b0, $urandom_range(1) ? CH_CR : CH_LF);
    endtask

    task automatic gen_token();
        int r;
        r = $urandom_range(99);
        if (r < 24) gen_keyword();
        else if (r < 38) gen_ident();
        else if (r < 50) gen_number();
        else if (r < 60) gen_text();
        else if (r < 67) gen_comment();
        else if (r < 80) send_item(1'b0, symbols[$urandom_range(symbols.len() - 1)]);
        else if (r < 93) repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom_range(255)));
        else send_eof();
        case ($urandom_range(3))
            0, 1: send_item(1'b0, blank_char());
            2: send_item(1'b0, symbols[$urandom_range(symbols.len() - 1)]);
            default: ;
        endcase
    endtask

    task automatic run_random(input int n);
        int target;
        target = bytes_sent + eofs_sent + n;
        while (bytes_sent + eofs_sent < target) gen_token();
    endtask

    initial begin
        for (int k = 0; k < KW_N; k++)
            if (keywords[k].len() > keywords[longest_kw].len()) longest_kw = k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Word closed by a symbol, real with extra dots, text holding the other quote,
        // comment, byte extremes, and end of stream after a word, a comment and a number.
        send_text("SI+");
        send_text("1.2.3;");
        send_text("'a\"'");
        send_text("#x\n");
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_text("_A9");
        send_eof();
        send_text("#c");
        send_eof();
        send_text("7");
        send_eof();

        run_random(500);

        // The sink holds off while bytes keep coming, so the output queue fills up.
        sink_hold_req = 1'b1;
        run_random(60);
        drain_tokens();

        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        run_random(400);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        run_random(440);

        send_eof();

        drain_tokens();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Lexed %0d source bytes and %0d end-of-stream transfers into %0d tokens,",
                 bytes_sent, eofs_sent, tokens_seen);
        $display("all compared in order; the longest lexeme reported was %0d bytes.",
                 longest_token);
        if (fail_count == 0 && pending_tokens == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/psl_pkg.sv
hdl/pseudocode_lexer_unit.sv
tb/lexer_token_check.sv
tb/testbench.sv
